>>> hw/rtl/tsp_pkg.sv
// tsp_pkg: item types, command codes and helpers shared by the timer slot pool
`default_nettype none
package tsp_pkg;

  typedef enum logic [2:0] {
    OP_CREATE        = 3'd0,
    OP_REARM         = 3'd1,
    OP_REARM_TIMEOUT = 3'd2,
    OP_DISARM        = 3'd3,
    OP_DELETE        = 3'd4,
    OP_READ_COUNT    = 3'd5,
    OP_TICK          = 3'd6,
    OP_CALLBACK_DONE = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_NO_SLOT   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // most fire items one tick may report
  localparam int MAX_FIRES = 32;
  localparam int FIRE_W    = 6;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] handle;
    logic [31:0] timeout;
    logic        periodic;
    logic        arm_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_handle;
    logic [31:0] count;
    logic        fired;
    logic        last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    in_item_t item;
    logic     reject;
  } cmd_t;

  // wrapping handle counter step, never zero
  function automatic logic [31:0] handle_inc(input logic [31:0] h);
    logic [31:0] n;
    n = h + 32'd1;
    if (n == 32'd0) n = 32'd1;
    return n;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tsp_front.sv
// tsp_front: input acceptance, fire_enable register and command classification
`default_nettype none
module tsp_front import tsp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic fire_enable_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_enable_r <= 1'b0;
    end else if (cfg_we) begin
      fire_enable_r <= cfg_wdata;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // refusals that need no slot state
  always_comb begin
    q_cmd.item   = in_item;
    q_cmd.reject = 1'b0;
    unique case (opcode_t'(in_item.opcode))
      OP_CREATE: begin
        q_cmd.reject = (in_item.timeout == 32'd0) || !fire_enable_r;
      end
      OP_TICK: begin
        q_cmd.reject = !fire_enable_r;
      end
      OP_REARM, OP_REARM_TIMEOUT: begin
        q_cmd.reject = (in_item.handle == 32'd0) || !fire_enable_r;
      end
      default: begin
        q_cmd.reject = (in_item.handle == 32'd0);
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/tsp_cmd_fifo.sv
// tsp_cmd_fifo: two-entry command queue between front and back
`default_nettype none
module tsp_cmd_fifo import tsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      full,
  output logic      empty
);

  cmd_t       buf_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_cmd = buf_r[rp_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= push_cmd;
  end

endmodule
`default_nettype wire

>>> hw/rtl/tsp_engine.sv
// tsp_engine: slot store, slot walk sequencer and result register
`default_nettype none
module tsp_engine import tsp_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN, S_EMIT} state_t;

  state_t      state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [31:0] counter_r, counter_nxt;
  logic [31:0] cand_r, cand_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic        p_valid_r, p_valid_nxt;
  logic [IW-1:0] p_idx_r, p_idx_nxt;
  logic        found_r, found_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [31:0] rel_cap_r, rel_cap_nxt;
  logic [31:0] cnt_cap_r, cnt_cap_nxt;
  logic        free_found_r, free_found_nxt;
  logic [IW-1:0] free_pos_r, free_pos_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] pend_h_r, pend_h_nxt;
  logic [FIRE_W-1:0] n_r, n_nxt;
  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [SLOTS-1:0] repeat_r, repeat_nxt;
  logic [SLOTS-1:0] incb_r, incb_nxt;

  // slot memories, one read address shared
  logic [31:0] hmem [SLOTS];
  logic [31:0] rmem [SLOTS];
  logic [31:0] cmem [SLOTS];
  logic [31:0] hq, rq, cq;
  logic        fetch;
  logic        we_h, we_r, we_c;
  logic [IW-1:0] wa;
  logic [31:0] wd_h, wd_r, wd_c;

  logic        out_free;
  logic        ld;
  out_item_t   ld_data;
  logic        hold;
  logic        fire_here;
  logic        is_tick;
  logic [31:0] key;
  logic        hit;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_tick   = (opcode_t'(cmd_r.item.opcode) == OP_TICK);
  assign key       = (opcode_t'(cmd_r.item.opcode) == OP_CREATE) ? cand_r : cmd_r.item.handle;
  assign hit       = used_r[p_idx_r] && (hq == key);
  assign fire_here = is_tick && p_valid_r && used_r[p_idx_r] && active_r[p_idx_r] &&
                     (cq == 32'd0) && (n_r < FIRE_W'(MAX_FIRES));
  // a second fire waits while the older pending item cannot leave
  assign hold      = fire_here && pend_r && !out_free;

  always_ff @(posedge clk) begin
    if (fetch) begin
      hq <= hmem[rd_idx_r[IW-1:0]];
      rq <= rmem[rd_idx_r[IW-1:0]];
      cq <= cmem[rd_idx_r[IW-1:0]];
    end
    if (we_h) hmem[wa] <= wd_h;
    if (we_r) rmem[wa] <= wd_r;
    if (we_c) cmem[wa] <= wd_c;
  end

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    counter_nxt    = counter_r;
    cand_nxt       = cand_r;
    rd_idx_nxt     = rd_idx_r;
    p_valid_nxt    = p_valid_r;
    p_idx_nxt      = p_idx_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    rel_cap_nxt    = rel_cap_r;
    cnt_cap_nxt    = cnt_cap_r;
    free_found_nxt = free_found_r;
    free_pos_nxt   = free_pos_r;
    pend_nxt       = pend_r;
    pend_h_nxt     = pend_h_r;
    n_nxt          = n_r;
    res_nxt        = res_r;
    used_nxt       = used_r;
    active_nxt     = active_r;
    repeat_nxt     = repeat_r;
    incb_nxt       = incb_r;
    q_pop          = 1'b0;
    fetch          = 1'b0;
    we_h           = 1'b0;
    we_r           = 1'b0;
    we_c           = 1'b0;
    wa             = p_idx_r;
    wd_h           = cand_r;
    wd_r           = cmd_r.item.timeout;
    wd_c           = 32'd0;
    ld             = 1'b0;
    ld_data        = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          rd_idx_nxt     = '0;
          p_valid_nxt    = 1'b0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          pend_nxt       = 1'b0;
          n_nxt          = '0;
          cand_nxt       = handle_inc(counter_r);
          if (q_cmd.reject) begin
            res_nxt   = '{ST_REJECTED, 32'd0, 32'd0, 1'b0, 1'b1};
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (!hold) begin
          // slot in the compare stage
          if (p_valid_r) begin
            if (is_tick) begin
              if (used_r[p_idx_r] && active_r[p_idx_r]) begin
                if (cq != 32'd0) begin
                  we_c = 1'b1;
                  wd_c = cq - 32'd1;
                end else if (fire_here) begin
                  we_c = 1'b1;
                  if (repeat_r[p_idx_r]) begin
                    wd_c              = rq;
                    incb_nxt[p_idx_r] = 1'b0;
                  end else begin
                    wd_c                = 32'hFFFF_FFFF;
                    active_nxt[p_idx_r] = 1'b0;
                    incb_nxt[p_idx_r]   = 1'b1;
                  end
                  if (pend_r) begin
                    ld      = 1'b1;
                    ld_data = '{ST_OK, pend_h_r, 32'd0, 1'b1, 1'b0};
                  end
                  pend_nxt   = 1'b1;
                  pend_h_nxt = hq;
                  n_nxt      = n_r + FIRE_W'(1);
                end
              end
            end else begin
              if (hit && !found_r) begin
                found_nxt   = 1'b1;
                pos_nxt     = p_idx_r;
                rel_cap_nxt = rq;
                cnt_cap_nxt = cq;
              end
              if (!used_r[p_idx_r] && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_pos_nxt   = p_idx_r;
              end
            end
          end
          // next slot read
          if (rd_idx_r != CW'(SLOTS)) begin
            fetch       = 1'b1;
            p_valid_nxt = 1'b1;
            p_idx_nxt   = rd_idx_r[IW-1:0];
            rd_idx_nxt  = rd_idx_r + CW'(1);
          end else begin
            p_valid_nxt = 1'b0;
            if (!p_valid_r) state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        state_nxt = S_EMIT;
        res_nxt   = '{ST_OK, 32'd0, 32'd0, 1'b0, 1'b1};
        wa        = pos_r;
        unique case (opcode_t'(cmd_r.item.opcode))
          OP_CREATE: begin
            counter_nxt = cand_r;
            if (found_r) begin
              // handle in use, try the next one
              cand_nxt       = handle_inc(cand_r);
              rd_idx_nxt     = '0;
              p_valid_nxt    = 1'b0;
              found_nxt      = 1'b0;
              free_found_nxt = 1'b0;
              state_nxt      = S_WALK;
            end else if (!free_found_r) begin
              res_nxt.status = ST_NO_SLOT;
            end else begin
              wa                     = free_pos_r;
              we_h                   = 1'b1;
              we_r                   = 1'b1;
              we_c                   = 1'b1;
              wd_c                   = cmd_r.item.arm_now ? cmd_r.item.timeout : 32'd0;
              used_nxt[free_pos_r]   = 1'b1;
              active_nxt[free_pos_r] = cmd_r.item.arm_now;
              repeat_nxt[free_pos_r] = cmd_r.item.periodic;
              incb_nxt[free_pos_r]   = 1'b0;
              res_nxt.result_handle  = cand_r;
            end
          end
          OP_TICK: begin
            if (pend_r) res_nxt = '{ST_OK, pend_h_r, 32'd0, 1'b1, 1'b1};
          end
          default: begin
            if (!found_r) begin
              res_nxt.status = ST_NOT_FOUND;
            end else begin
              unique case (opcode_t'(cmd_r.item.opcode))
                OP_REARM_TIMEOUT: begin
                  we_r              = 1'b1;
                  we_c              = 1'b1;
                  wd_c              = cmd_r.item.timeout;
                  active_nxt[pos_r] = 1'b1;
                end
                OP_REARM: begin
                  we_c              = 1'b1;
                  wd_c              = rel_cap_r;
                  active_nxt[pos_r] = 1'b1;
                end
                OP_DISARM: begin
                  active_nxt[pos_r] = 1'b0;
                end
                OP_DELETE: begin
                  used_nxt[pos_r]   = 1'b0;
                  active_nxt[pos_r] = 1'b0;
                  repeat_nxt[pos_r] = 1'b0;
                  incb_nxt[pos_r]   = 1'b0;
                end
                OP_READ_COUNT: begin
                  res_nxt.count = cnt_cap_r;
                end
                default: begin
                  incb_nxt[pos_r] = 1'b0;
                  if (!active_r[pos_r] && !repeat_r[pos_r]) begin
                    used_nxt[pos_r]   = 1'b0;
                    repeat_nxt[pos_r] = 1'b0;
                  end
                end
              endcase
            end
          end
        endcase
      end

      S_EMIT: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_data   = res_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result register
    if (ld)             out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else                out_valid_nxt = 1'b0;
    out_item_nxt = ld ? ld_data : out_item_r;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      counter_r    <= 32'd0;
      p_valid_r    <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      used_r       <= '0;
      active_r     <= '0;
      repeat_r     <= '0;
      incb_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      counter_r    <= counter_nxt;
      p_valid_r    <= p_valid_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      used_r       <= used_nxt;
      active_r     <= active_nxt;
      repeat_r     <= repeat_nxt;
      incb_r       <= incb_nxt;
    end
    cmd_r        <= cmd_nxt;
    cand_r       <= cand_nxt;
    rd_idx_r     <= rd_idx_nxt;
    p_idx_r      <= p_idx_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    rel_cap_r    <= rel_cap_nxt;
    cnt_cap_r    <= cnt_cap_nxt;
    free_found_r <= free_found_nxt;
    free_pos_r   <= free_pos_nxt;
    pend_h_r     <= pend_h_nxt;
    n_r          <= n_nxt;
    res_r        <= res_nxt;
    out_item_r   <= out_item_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/timer_slot_pool.sv
// timer_slot_pool: top level of the timer slot pool
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_item (in_item_t)
//  out_    | output    | out_valid / out_stall | out_item (out_item_t)
//  cfg_    | input     | cfg_we                | cfg_wdata (fire_enable)
//
// every non-refused command walks all SLOTS entries of the slot memory, one slot
// a cycle while the walk is not stalled; a refused command skips the walk
// a create repeats the walk once for each generated handle already in use
// a tick stalls its walk while a fire item waits on a stalled output
// synchronous active-low reset clears all slots at once, no clearing pass
// the two-entry command queue keeps accepting items while the back part works, until it is full
`default_nettype none
module timer_slot_pool import tsp_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_in_cmd, q_out_cmd;

  // accept and classify
  tsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd)
  );

  // command queue
  tsp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // slot engine
  tsp_engine #(.SLOTS(SLOTS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_out_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> tb/tb_timer_slot_pool_chk.sv
// checker for the timer slot pool: predicts result items and compares them
module tb_timer_slot_pool_chk import tsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 32;

  // predicted pool state
  logic        fire_en;
  logic        used     [NSLOT];
  logic [31:0] hnd      [NSLOT];
  logic [31:0] reload   [NSLOT];
  logic [31:0] cnt      [NSLOT];
  logic        active   [NSLOT];
  logic        repeat_q [NSLOT];
  logic        in_cb    [NSLOT];
  logic [31:0] hcount;

  out_item_t expected_results[$];

  assign pending = expected_results.size();

  function automatic int find_slot(logic [31:0] h);
    for (int i = 0; i < NSLOT; i++)
      if (used[i] && hnd[i] == h) return i;
    return NSLOT;
  endfunction

  function automatic void clear_slot(int i);
    used[i] = 0; hnd[i] = 0; reload[i] = 0; cnt[i] = 0;
    active[i] = 0; repeat_q[i] = 0; in_cb[i] = 0;
  endfunction

  function automatic void push_res(logic [1:0] st, logic [31:0] h, logic [31:0] c,
                                   logic f, logic l);
    out_item_t r;
    r.status = st; r.result_handle = h; r.count = c; r.fired = f; r.last = l;
    expected_results.push_back(r);
  endfunction

  // apply one command to the predicted pool
  function automatic void predict_command(in_item_t it);
    int pos;
    int nfire;
    logic [31:0] nh;
    opcode_t op;
    op = opcode_t'(it.opcode);
    if (op == OP_CREATE) begin
      if (it.timeout == 0 || !fire_en) begin
        push_res(ST_REJECTED, 0, 0, 0, 1);
        return;
      end
      do begin
        hcount = hcount + 1;
        if (hcount == 0) hcount = 1;
        nh = hcount;
      end while (find_slot(nh) != NSLOT);
      pos = NSLOT;
      for (int i = NSLOT - 1; i >= 0; i--) if (!used[i]) pos = i;
      if (pos == NSLOT) begin
        push_res(ST_NO_SLOT, 0, 0, 0, 1);
        return;
      end
      clear_slot(pos);
      used[pos] = 1; hnd[pos] = nh; reload[pos] = it.timeout;
      repeat_q[pos] = it.periodic;
      if (it.arm_now) begin
        active[pos] = 1; cnt[pos] = it.timeout;
      end
      push_res(ST_OK, nh, 0, 0, 1);
      return;
    end
    if (op == OP_TICK) begin
      if (!fire_en) begin
        push_res(ST_REJECTED, 0, 0, 0, 1);
        return;
      end
      nfire = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!used[i] || !active[i]) continue;
        if (cnt[i] != 0) begin
          cnt[i] = cnt[i] - 1;
          continue;
        end
        if (nfire >= MAX_FIRES) continue;
        push_res(ST_OK, hnd[i], 0, 1, 0);
        nfire++;
        if (repeat_q[i]) begin
          in_cb[i] = 0; active[i] = 1; cnt[i] = reload[i];
        end else begin
          cnt[i] = 32'hFFFF_FFFF; active[i] = 0; in_cb[i] = 1;
        end
      end
      if (nfire == 0) push_res(ST_OK, 0, 0, 0, 1);
      else expected_results[$].last = 1;
      return;
    end
    // per-timer commands
    if (it.handle == 0 || ((op == OP_REARM || op == OP_REARM_TIMEOUT) && !fire_en)) begin
      push_res(ST_REJECTED, 0, 0, 0, 1);
      return;
    end
    pos = find_slot(it.handle);
    if (pos == NSLOT) begin
      push_res(ST_NOT_FOUND, 0, 0, 0, 1);
      return;
    end
    case (op)
      OP_REARM_TIMEOUT: begin
        reload[pos] = it.timeout; active[pos] = 1; cnt[pos] = it.timeout;
      end
      OP_REARM: begin
        active[pos] = 1; cnt[pos] = reload[pos];
      end
      OP_DISARM: active[pos] = 0;
      OP_DELETE: clear_slot(pos);
      OP_READ_COUNT: begin
        push_res(ST_OK, 0, cnt[pos], 0, 1);
        return;
      end
      default: begin
        in_cb[pos] = 0;
        if (!active[pos] && !repeat_q[pos]) clear_slot(pos);
      end
    endcase
    push_res(ST_OK, 0, 0, 0, 1);
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fire_en = 0;
      for (int i = 0; i < NSLOT; i++) clear_slot(i);
      hcount = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item, actual %p", $realtime, out_item);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (want != out_item) begin
            $display("%0t: mismatch, expected %p actual %p", $realtime, want, out_item);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_command(in_item);
      if (cfg_we) fire_en = cfg_wdata;
    end
  end

  initial fail_count = 0;
endmodule

>>> tb/tb_timer_slot_pool.sv
// testbench top for the timer slot pool: stimulus, stall patterns and verdict
module tb_timer_slot_pool import tsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_item;
  logic      cfg_we = 0;
  logic      cfg_wdata = 0;
  int        fail_count;
  int        pending;
  bit        hold_off = 0;
  logic [31:0] known_handles[$];

  timer_slot_pool u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  tb_timer_slot_pool_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // collect created handles so per-timer commands hit real slots
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_item.status == ST_OK &&
        out_item.result_handle != 0 && !out_item.fired)
      known_handles.push_back(out_item.result_handle);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // offer one item and wait until it is taken
  task automatic send_cmd(opcode_t op, logic [31:0] h, logic [31:0] tmo, logic per, logic arm);
    in_item.opcode <= op;
    in_item.handle <= h;
    in_item.timeout <= tmo;
    in_item.periodic <= per;
    in_item.arm_now <= arm;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  // wait until all results are in, then let the pool settle
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_enable(logic v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1 || known_handles.size() == 0) return $urandom();
    return known_handles[$urandom_range(0, known_handles.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_timeout();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom();
    if (r == 2) return 32'hFFFF_FFFF;
    return $urandom_range(1, 4);
  endfunction

  initial begin
    opcode_t op;
    logic [31:0] h;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // refused while disabled, handle zero, unknown handle
    send_cmd(OP_CREATE, 0, 5, 0, 1);
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_REARM, 1, 0, 0, 0);
    send_cmd(OP_DISARM, 0, 0, 0, 0);
    send_cmd(OP_READ_COUNT, 32'hFFFF_FFFF, 0, 0, 0);
    send_cmd(OP_CALLBACK_DONE, 7, 0, 0, 0);

    write_enable(1);
    // create extremes, fire one-shot and periodic, callback and rearm paths
    send_cmd(OP_CREATE, 0, 0, 0, 1);
    send_cmd(OP_CREATE, 0, 1, 0, 1);
    send_cmd(OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
    send_cmd(OP_CREATE, 0, 1, 1, 1);
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_READ_COUNT, 1, 0, 0, 0);
    send_cmd(OP_CALLBACK_DONE, 1, 0, 0, 0);
    send_cmd(OP_REARM_TIMEOUT, 2, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_REARM, 2, 0, 0, 0);
    send_cmd(OP_DISARM, 3, 0, 0, 0);
    send_cmd(OP_CALLBACK_DONE, 2, 0, 0, 0);
    send_cmd(OP_DELETE, 3, 0, 0, 0);
    // fill the pool past its size, then many fires in one tick
    for (int i = 0; i < 34; i++) send_cmd(OP_CREATE, 0, 1, i[0], 1);
    hold_off = 1;
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_READ_COUNT, 5, 0, 0, 0);
    drain();
    for (int i = 1; i <= 20; i++) send_cmd(OP_DELETE, i, 0, 0, 0);

    // random phases, each with its own enable setting
    for (int ph = 0; ph < 4; ph++) begin
      write_enable(ph != 2);
      repeat (10) begin
        op = opcode_t'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) op = OP_TICK;
        h = pick_handle();
        send_cmd(op, h, pick_timeout(), $urandom_range(0, 1), $urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 50));
      end
    end
    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
